>>> hdl/pagerank_delta_engine_core_assert.svh
// ----------------------------------------------------------------------------
// pagerank_delta_engine_core_assert
// Assertion macros for the delta PageRank engine; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef PAGERANK_DELTA_ENGINE_CORE_ASSERT_SVH
`define PAGERANK_DELTA_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PDE_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pde assertion failed");
`define PDE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pde assertion failed");
`else
`define PDE_ASSERT_RST(lbl, clk, rst_n, prop)
`define PDE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/pdelta_pkg.sv
// ----------------------------------------------------------------------------
// pdelta_pkg
// Shared types, opcodes, register indexes and reset values.
// ----------------------------------------------------------------------------
package pdelta_pkg;

    localparam int DEF_MAX_VERTICES  = 4096;
    localparam int DEF_FRACTION_BITS = 30;
    localparam int DEF_QUEUE_DEPTH   = 4;

    localparam int OPCODE_W  = 3;
    localparam int VERTEX_W  = 12;
    localparam int DEGREE_W  = 20;
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 8;
    localparam int L1_W      = 40;
    localparam int DIV_STEPS = 32;

    localparam logic [OPCODE_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_EDGE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_APPLY = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_END   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND   = 8'd3;

    localparam logic [CFG_W-1:0] RST_DAMPING = 31'd912680550;
    localparam logic [CFG_W-1:0] RST_SHARE   = 31'd262144;
    localparam logic [CFG_W-1:0] RST_RATIO   = 31'd10737418;
    localparam logic [CFG_W-1:0] RST_BOUND   = 31'd107;

    localparam logic [L1_W-1:0] L1_MAX = {L1_W{1'b1}};

    typedef enum logic [2:0] {
        K_INIT,
        K_EDGE,
        K_APPLY,
        K_END,
        K_READ,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dst;
        logic [DEGREE_W-1:0] deg;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic                start;
        logic [VALUE_W-1:0]  dividend;
        logic [DEGREE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic signed [VALUE_W-1:0] rank_value;
        logic signed [VALUE_W-1:0] delta_value;
        logic                      is_active;
        logic [L1_W-1:0]           l1_norm;
        logic                      converged;
        logic                      error_flag;
    } t_result;

    function automatic t_kind classify(input logic [OPCODE_W-1:0] op);
        t_kind k;
        unique case (op)
            OP_INIT:  k = K_INIT;
            OP_EDGE:  k = K_EDGE;
            OP_APPLY: k = K_APPLY;
            OP_END:   k = K_END;
            OP_READ:  k = K_READ;
            default:  k = K_NOP;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/pdelta_ifs.sv
// ----------------------------------------------------------------------------
// pdelta_ifs
// Valid/ready channel interfaces: command input, result output, config write.
// ----------------------------------------------------------------------------
interface pdelta_in_if;
    import pdelta_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VERTEX_W-1:0] src_vertex;
    logic [VERTEX_W-1:0] dst_vertex;
    logic [DEGREE_W-1:0] out_degree;
    modport source (output valid, opcode, src_vertex, dst_vertex, out_degree, input ready);
    modport sink   (input valid, opcode, src_vertex, dst_vertex, out_degree, output ready);
endinterface

interface pdelta_out_if;
    import pdelta_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] rank_value;
    logic signed [VALUE_W-1:0] delta_value;
    logic                      is_active;
    logic [L1_W-1:0]           l1_norm;
    logic                      converged;
    logic                      error_flag;
    modport source (output valid, rank_value, delta_value, is_active, l1_norm, converged,
                    error_flag, input ready);
    modport sink   (input valid, rank_value, delta_value, is_active, l1_norm, converged,
                    error_flag, output ready);
endinterface

interface pdelta_cfg_if;
    import pdelta_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/pagerank_delta_engine_core.sv
// ----------------------------------------------------------------------------
// pagerank_delta_engine_core
// Delta PageRank vertex store and update engine, signed Q2.30 fixed point.
// ----------------------------------------------------------------------------
// Channels: i_in takes commands (init, edge, apply, end round, read), o_out
// returns exactly one result per command, i_cfg writes the four registers
// (index 0..3) and is always ready; write it only while the engine is idle.
// A front stage reduces vertex indexes and queues up to QUEUE_DEPTH commands,
// so i_in keeps accepting one transaction per cycle while the back end works,
// as long as the queue has room. The back end runs one command at a time.
// An apply runs a chain of three multiplies on one shared 32x31 multiplier;
// an edge whose source is active with nonzero degree waits on the 32-step
// bit-serial divider. Commands pass the front stage register and the queue
// before the back end sees them.
// Reset clears the queue, the output register and the L1 accumulator, sets
// the round flag, loads register defaults; vertex stores hold no reset value.
// When o_out stalls the result stays registered and the back end waits; the
// queue fills and then i_in.ready drops.
// ----------------------------------------------------------------------------
module pagerank_delta_engine_core #(
    parameter int MAX_VERTICES  = pdelta_pkg::DEF_MAX_VERTICES,
    parameter int FRACTION_BITS = pdelta_pkg::DEF_FRACTION_BITS,
    parameter int QUEUE_DEPTH   = pdelta_pkg::DEF_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pdelta_in_if.sink    i_in,
    pdelta_out_if.source o_out,
    pdelta_cfg_if.sink   i_cfg
);
    import pdelta_pkg::*;

    t_head w_head;
    logic  w_pop;

    pdelta_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    pdelta_back #(
        .MAX_VERTICES  (MAX_VERTICES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

>>> hdl/pdelta_front.sv
// ----------------------------------------------------------------------------
// pdelta_front
// Accepts commands, reduces vertex indexes modulo the store depth, classifies
// the opcode and queues the item for the back end.
// ----------------------------------------------------------------------------
module pdelta_front #(
    parameter int MAX_VERTICES = pdelta_pkg::DEF_MAX_VERTICES,
    parameter int QUEUE_DEPTH  = pdelta_pkg::DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pdelta_in_if.sink         i_in,
    output pdelta_pkg::t_head o_head,
    input  logic              i_pop
);
    import pdelta_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int K  = VERTEX_W + AW;
    localparam logic [K:0] RECIP =
        (K+1)'(((64'd1 << K) + 64'(MAX_VERTICES) - 64'd1) / 64'(MAX_VERTICES));
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [VERTEX_W-1:0] quo(input logic [VERTEX_W-1:0] v);
        logic [VERTEX_W+K:0] p;
        p = (VERTEX_W+K+1)'(v) * (VERTEX_W+K+1)'(RECIP);
        return p[K +: VERTEX_W];
    endfunction

    function automatic logic [VERTEX_W-1:0] rem(input logic [VERTEX_W-1:0] v,
                                                input logic [VERTEX_W-1:0] q);
        logic [VERTEX_W+AW:0] m;
        m = (VERTEX_W+AW+1)'(q) * (VERTEX_W+AW+1)'(MAX_VERTICES);
        return v - m[VERTEX_W-1:0];
    endfunction

    logic                r_s1_valid;
    logic [OPCODE_W-1:0] r_s1_op;
    logic [VERTEX_W-1:0] r_s1_src, r_s1_dst, r_s1_qs, r_s1_qd;
    logic [DEGREE_W-1:0] r_s1_deg;

    t_item               r_fifo [QUEUE_DEPTH];
    logic [PW-1:0]       r_wp, r_rp;
    logic [CW-1:0]       r_cnt;

    logic                w_full, w_push, w_take;
    t_item               w_item;

    assign w_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign w_push  = r_s1_valid && !w_full;
    assign i_in.ready = !r_s1_valid || w_push;
    assign w_take  = i_in.valid && i_in.ready;

    assign w_item.kind = classify(r_s1_op);
    assign w_item.src  = rem(r_s1_src, r_s1_qs);
    assign w_item.dst  = rem(r_s1_dst, r_s1_qd);
    assign w_item.deg  = r_s1_deg;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (w_take) begin
            r_s1_op  <= i_in.opcode;
            r_s1_src <= i_in.src_vertex;
            r_s1_dst <= i_in.dst_vertex;
            r_s1_deg <= i_in.out_degree;
            r_s1_qs  <= quo(i_in.src_vertex);
            r_s1_qd  <= quo(i_in.dst_vertex);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_item;
        end
    end

endmodule

>>> hdl/pdelta_div.sv
// ----------------------------------------------------------------------------
// pdelta_div
// Restoring divider, one quotient bit per cycle: magnitude of delta / degree.
// ----------------------------------------------------------------------------
module pdelta_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pdelta_pkg::t_div_req i_req,
    output pdelta_pkg::t_div_rsp o_rsp
);
    import pdelta_pkg::*;

    localparam int SW = $clog2(DIV_STEPS);

    logic [DEGREE_W-1:0] r_rem, r_div;
    logic [VALUE_W-1:0]  r_quo;
    logic [SW-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [DEGREE_W:0]   w_trial;
    logic                w_ge;

    assign w_trial = {r_rem, r_quo[VALUE_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? DEGREE_W'(w_trial - {1'b0, r_div}) : w_trial[DEGREE_W-1:0];
            r_quo <= {r_quo[VALUE_W-2:0], w_ge};
        end
    end

endmodule

>>> hdl/pdelta_back.sv
// ----------------------------------------------------------------------------
// pdelta_back
// Vertex stores, configuration registers and the sequencer that executes
// init, edge, apply, end-round and read, with one output register.
// ----------------------------------------------------------------------------
`include "pagerank_delta_engine_core_assert.svh"

module pdelta_back #(
    parameter int MAX_VERTICES  = pdelta_pkg::DEF_MAX_VERTICES,
    parameter int FRACTION_BITS = pdelta_pkg::DEF_FRACTION_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdelta_pkg::t_head i_head,
    output logic              o_pop,
    pdelta_cfg_if.sink        i_cfg,
    pdelta_out_if.source      o_out
);
    import pdelta_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEC  = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_EWR  = 4'd3;
    localparam logic [3:0] ST_MNS  = 4'd4;
    localparam logic [3:0] ST_MADD = 4'd5;
    localparam logic [3:0] ST_CALC = 4'd6;
    localparam logic [3:0] ST_MTHR = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    function automatic logic [AW-1:0] to_addr(input logic [VERTEX_W-1:0] v);
        logic [AW+VERTEX_W-1:0] t;
        t = {{AW{1'b0}}, v};
        return t[AW-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v > 36'sh07FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -36'sh080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] abs32(input logic signed [VALUE_W-1:0] v);
        return v[VALUE_W-1] ? VALUE_W'(-v) : VALUE_W'(v);
    endfunction

    function automatic logic signed [35:0] rnd(input logic [62:0] p, input logic neg);
        logic [62:0] s;
        logic [62:0] sh;
        logic signed [35:0] m;
        s  = p + (63'd1 << (FRACTION_BITS - 1));
        sh = s >> FRACTION_BITS;
        m  = $signed(sh[35:0]);
        return neg ? -m : m;
    endfunction

    logic [CFG_W-1:0] r_damp, r_share, r_ratio, r_bound;

    logic [DEGREE_W-1:0]       m_deg   [MAX_VERTICES];
    logic signed [VALUE_W-1:0] m_rank  [MAX_VERTICES];
    logic signed [VALUE_W-1:0] m_delta [MAX_VERTICES];
    logic signed [VALUE_W-1:0] m_nsum  [MAX_VERTICES];
    logic                      m_act   [MAX_VERTICES];

    logic [DEGREE_W-1:0]       r_q_deg;
    logic signed [VALUE_W-1:0] r_q_rank, r_q_delta, r_q_nsum;
    logic                      r_q_act;

    logic [3:0]                r_state, n_state;
    t_item                     r_it;
    logic                      r_first, n_first;
    logic [L1_W-1:0]           r_acc, n_acc;
    logic                      r_dsign;
    logic [62:0]               r_prod;
    logic                      r_neg;
    logic signed [35:0]        r_p1;
    logic signed [VALUE_W-1:0] r_rank_new, r_delta;
    logic                      r_out_valid;
    t_result                   r_out;

    logic [AW-1:0]             w_rd_addr, w_wr_addr;
    logic                      w_out_free, w_emit;
    t_result                   w_res;
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;
    logic                      w_we_init, w_we_apply, w_we_edge;
    logic [VALUE_W-1:0]        w_mul_a;
    logic [CFG_W-1:0]          w_mul_b;
    logic                      w_mul_neg;
    logic [62:0]               w_prod;
    logic signed [32:0]        w_om;
    logic signed [35:0]        w_added, w_thr, w_sq;
    logic signed [VALUE_W-1:0] w_t, w_calc_rank, w_calc_delta, w_rank_fin, w_esum;
    logic                      w_act;
    logic [L1_W:0]             w_acc_sum;
    logic [L1_W-1:0]           w_acc_sat;

    pdelta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp  <= RST_DAMPING;
            r_share <= RST_SHARE;
            r_ratio <= RST_RATIO;
            r_bound <= RST_BOUND;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DAMPING: r_damp  <= i_cfg.data;
                CFG_SHARE:   r_share <= i_cfg.data;
                CFG_RATIO:   r_ratio <= i_cfg.data;
                CFG_BOUND:   r_bound <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            ST_IDLE:        w_rd_addr = to_addr(i_head.item.src);
            ST_DIV, ST_EWR: w_rd_addr = to_addr(r_it.dst);
            default:        w_rd_addr = to_addr(r_it.src);
        endcase
    end
    assign w_wr_addr = (r_state == ST_EWR) ? to_addr(r_it.dst) : to_addr(r_it.src);

    assign w_om = $signed(33'(1) << FRACTION_BITS) - $signed({2'b00, r_damp});

    always_comb begin
        case (r_state)
            ST_MADD: begin
                w_mul_a   = w_om[32] ? VALUE_W'(-w_om) : VALUE_W'(w_om);
                w_mul_b   = r_share;
                w_mul_neg = w_om[32];
            end
            ST_MTHR, ST_FIN: begin
                w_mul_a   = abs32(r_rank_new);
                w_mul_b   = r_ratio;
                w_mul_neg = r_rank_new[VALUE_W-1];
            end
            default: begin
                w_mul_a   = abs32(r_q_nsum);
                w_mul_b   = r_damp;
                w_mul_neg = r_q_nsum[VALUE_W-1];
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    assign w_added      = rnd(r_prod, r_neg);
    assign w_t          = sat32(r_p1 + w_added);
    assign w_calc_rank  = r_first ? sat32(36'(r_q_rank) + 36'(w_t)) : r_q_rank;
    assign w_calc_delta = r_first ? sat32(36'(w_t) - $signed({5'b0, r_share})) : sat32(r_p1);

    assign w_thr      = rnd(r_prod, r_neg);
    assign w_act      = $signed({4'b0, abs32(r_delta)}) > w_thr;
    assign w_rank_fin = (!r_first && w_act) ? sat32(36'(r_rank_new) + 36'(r_delta))
                                            : r_rank_new;
    assign w_acc_sum  = {1'b0, r_acc} + (L1_W+1)'(abs32(r_delta));
    assign w_acc_sat  = w_acc_sum[L1_W] ? L1_MAX : w_acc_sum[L1_W-1:0];

    assign w_sq   = r_dsign ? -$signed({4'b0, w_div_rsp.quotient})
                            : $signed({4'b0, w_div_rsp.quotient});
    assign w_esum = sat32(36'(r_q_nsum) + w_sq);

    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_first    = r_first;
        n_acc      = r_acc;
        o_pop      = 1'b0;
        w_emit     = 1'b0;
        w_res      = '0;
        w_res.l1_norm = r_acc;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = abs32(r_q_delta);
        w_div_req.divisor  = r_q_deg;
        w_we_init  = 1'b0;
        w_we_apply = 1'b0;
        w_we_edge  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                unique case (r_it.kind)
                    K_INIT: begin
                        if (w_out_free) begin
                            w_emit    = 1'b1;
                            w_we_init = 1'b1;
                            n_first   = 1'b1;
                            n_state   = ST_IDLE;
                        end
                    end
                    K_EDGE: begin
                        if (r_q_act && r_q_deg != '0) begin
                            w_div_req.start = 1'b1;
                            n_state         = ST_DIV;
                        end else if (w_out_free) begin
                            w_emit           = 1'b1;
                            w_res.error_flag = r_q_act;
                            n_state          = ST_IDLE;
                        end
                    end
                    K_APPLY: n_state = ST_MNS;
                    K_END: begin
                        if (w_out_free) begin
                            w_emit          = 1'b1;
                            w_res.converged = (r_acc < L1_W'(r_bound));
                            n_first         = 1'b0;
                            n_acc           = '0;
                            n_state         = ST_IDLE;
                        end
                    end
                    K_READ: begin
                        if (w_out_free) begin
                            w_emit           = 1'b1;
                            w_res.rank_value = r_q_rank;
                            n_state          = ST_IDLE;
                        end
                    end
                    default: begin
                        if (w_out_free) begin
                            w_emit        = 1'b1;
                            w_res.l1_norm = '0;
                            n_state       = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_DIV:  if (w_div_rsp.done) n_state = ST_EWR;
            ST_EWR: begin
                if (w_out_free) begin
                    w_emit    = 1'b1;
                    w_we_edge = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_MNS:  n_state = ST_MADD;
            ST_MADD: n_state = ST_CALC;
            ST_CALC: n_state = ST_MTHR;
            ST_MTHR: n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) begin
                    w_emit            = 1'b1;
                    w_we_apply        = 1'b1;
                    w_res.rank_value  = w_rank_fin;
                    w_res.delta_value = r_delta;
                    w_res.is_active   = w_act;
                    w_res.l1_norm     = w_acc_sat;
                    n_acc             = w_acc_sat;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= 1'b1;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_acc   <= n_acc;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it <= i_head.item;
        end
        if (w_div_req.start) begin
            r_dsign <= r_q_delta[VALUE_W-1];
        end
        if (w_emit) begin
            r_out <= w_res;
        end
        r_prod <= w_prod;
        r_neg  <= w_mul_neg;
        if (r_state == ST_MADD) begin
            r_p1 <= rnd(r_prod, r_neg);
        end
        if (r_state == ST_CALC) begin
            r_rank_new <= w_calc_rank;
            r_delta    <= w_calc_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_init) begin
            m_deg[w_wr_addr] <= r_it.deg;
        end
        if (w_we_init || w_we_apply) begin
            m_rank[w_wr_addr]  <= w_we_apply ? w_rank_fin : '0;
            m_delta[w_wr_addr] <= w_we_apply ? r_delta : $signed({1'b0, r_share});
            m_act[w_wr_addr]   <= w_we_apply ? w_act : 1'b1;
        end
        if (w_we_init || w_we_apply || w_we_edge) begin
            m_nsum[w_wr_addr] <= w_we_edge ? w_esum : '0;
        end
        r_q_deg   <= m_deg[w_rd_addr];
        r_q_rank  <= m_rank[w_rd_addr];
        r_q_delta <= m_delta[w_rd_addr];
        r_q_nsum  <= m_nsum[w_rd_addr];
        r_q_act   <= m_act[w_rd_addr];
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.rank_value  = r_out.rank_value;
    assign o_out.delta_value = r_out.delta_value;
    assign o_out.is_active   = r_out.is_active;
    assign o_out.l1_norm     = r_out.l1_norm;
    assign o_out.converged   = r_out.converged;
    assign o_out.error_flag  = r_out.error_flag;

    `PDE_ASSERT_RST(a_pop_idle, i_clk, i_rst_n, o_pop |-> (r_state == ST_IDLE && i_head.valid))
    `PDE_ASSERT_RST(a_div_from_dec, i_clk, i_rst_n, w_div_req.start |-> (r_state == ST_DEC))
    `PDE_ASSERT_RST(a_div_done_state, i_clk, i_rst_n, w_div_rsp.done |-> (r_state == ST_DIV))
    `PDE_ASSERT_RST(a_ewr_after_div, i_clk, i_rst_n, (r_state == ST_EWR) |-> ($past(r_state) == ST_DIV || $past(r_state) == ST_EWR))

endmodule
